### design/box_avg_pkg.sv
package box_avg_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int CFG_W     = 13;
    localparam int SUM_DEPTH = 2 * MAX_DIM;
    localparam int ADDR_W    = $clog2(SUM_DEPTH);
    localparam int SUM_W     = 32;
    localparam int CNT_W     = 2 * DIM_W + 1;
    localparam int IDX_W     = 4;

    localparam logic [IDX_W-1:0] CFG_SRC_W = 4'd0;
    localparam logic [IDX_W-1:0] CFG_SRC_H = 4'd1;
    localparam logic [IDX_W-1:0] CFG_DST_W = 4'd2;
    localparam logic [IDX_W-1:0] CFG_DST_H = 4'd3;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic              overwrite;
        logic              capture;
        logic              div_start;
        logic [CNT_W-1:0]  count;
    } lane_ctrl_t;

endpackage

### design/box_average_image_downscale.sv
// Area-average RGB888 downscaler. Source pixels enter in raster order; each
// output pixel is the rounded mean (ties to even) of its source window, and
// is divided out once the last source pixel of that window is taken. Three
// channel lanes each keep two output rows of column sums in a single-port-pair
// memory and do their own 32-step divide. After a source pixel is accepted,
// each of the up to four window sums it touches gets a read-modify-write
// (S_RD, then S_WR); a pixel that closes a window then waits for the divide
// (S_DIV) and the result hand-off (S_OUT). Any configuration write restarts
// the frame through S_INIT before the next pixel is taken.
module box_average_image_downscale
    import box_avg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             pixel_valid,
    output logic             pixel_ready,
    input  pixel_t           pixel,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_WR   = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [CFG_W-1:0] sw, sh, tw, th;

    logic [DIM_W-1:0] c_reg, c_next, r_reg, r_next;
    logic [DIM_W-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic [DIM_W-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic [CFG_W-1:0] rx0_reg, rx0_next, rx1_reg, rx1_next;
    logic [CFG_W-1:0] ry0_reg, ry0_next, ry1_reg, ry1_next;
    logic [DIM_W-1:0] xs_reg, xs_next, ys_reg, ys_next;

    logic [1:0]       p_reg, p_next;
    pixel_t           pix_reg;
    logic             hit_reg, rend_reg, fend_reg;
    logic [CNT_W-1:0] count_reg;

    logic             res_valid_reg, res_valid_next;
    result_t          res_reg;

    logic             x_split, y_split, col_end, row_end_w;
    logic [DIM_W-1:0] start_x, start_y;
    logic [CFG_W-1:0] wx, wy;
    logic [2*CFG_W-1:0] prod;
    logic             accept, pair_ok, last_pair, exiting;
    logic [DIM_W-1:0] oy, ox;
    logic             ovw;
    logic [CFG_W:0]   sx0, sx1, sy0, sy1;

    lane_ctrl_t       ctrl;
    logic [7:0]       mean_r, mean_g, mean_b;
    logic             done_r, done_g, done_b;

    always_comb
    begin
        sw = (src_w_reg == '0) ? CFG_W'(1)
           : (src_w_reg > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : src_w_reg;
        sh = (src_h_reg == '0) ? CFG_W'(1)
           : (src_h_reg > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : src_h_reg;
        tw = (dst_w_reg == '0) ? CFG_W'(1) : (dst_w_reg > sw) ? sw : dst_w_reg;
        th = (dst_h_reg == '0) ? CFG_W'(1) : (dst_h_reg > sh) ? sh : dst_h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_W'(1920);
            src_h_reg <= CFG_W'(1080);
            dst_w_reg <= CFG_W'(960);
            dst_h_reg <= CFG_W'(540);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SRC_W: src_w_reg <= cfg_data;
                CFG_SRC_H: src_h_reg <= cfg_data;
                CFG_DST_W: dst_w_reg <= cfg_data;
                CFG_DST_H: dst_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // window geometry of the current source pixel
    assign x_split   = (x1_reg != x0_reg);
    assign y_split   = (y1_reg != y0_reg);
    assign col_end   = x_split || (rx1_reg == sw - CFG_W'(1));
    assign row_end_w = y_split || (ry1_reg == sh - CFG_W'(1));
    assign start_x   = (!x_split && rx0_reg == '0) ? c_reg : xs_reg;
    assign start_y   = (!y_split && ry0_reg == '0) ? r_reg : ys_reg;
    assign wx        = {1'b0, c_reg} + CFG_W'(1) - {1'b0, start_x};
    assign wy        = {1'b0, r_reg} + CFG_W'(1) - {1'b0, start_y};
    assign prod      = wx * wy;

    assign pixel_ready = (state_reg == S_IDLE) && !cfg_write;
    assign accept      = pixel_valid && pixel_ready;

    assign pair_ok   = (!p_reg[1] || y_split) && (!p_reg[0] || x_split);
    assign last_pair = (p_reg == 2'd3);
    assign oy        = p_reg[1] ? y1_reg : y0_reg;
    assign ox        = p_reg[0] ? x1_reg : x0_reg;
    assign ovw       = (p_reg[1] || ry0_reg == '0) && (p_reg[0] || rx0_reg == '0);
    assign exiting   = last_pair && ((state_reg == S_WR) || (state_reg == S_RD && !pair_ok));

    always_comb
    begin
        ctrl.rd_en     = (state_reg == S_RD) && pair_ok;
        ctrl.wr_en     = (state_reg == S_WR);
        ctrl.addr      = {oy[0], ox};
        ctrl.overwrite = ovw;
        ctrl.capture   = hit_reg && (p_reg == 2'd0);
        ctrl.div_start = exiting && hit_reg;
        ctrl.count     = count_reg;
    end

    always_comb
    begin
        sx0 = {1'b0, rx0_reg} + {1'b0, tw};
        sx1 = {1'b0, rx1_reg} + {1'b0, tw};
        sy0 = {1'b0, ry0_reg} + {1'b0, th};
        sy1 = {1'b0, ry1_reg} + {1'b0, th};
    end

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        rx0_next       = rx0_reg;
        rx1_next       = rx1_reg;
        ry0_next       = ry0_reg;
        ry1_next       = ry1_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        res_valid_next = res_valid_reg && !result_ready;

        unique case (state_reg)
            S_INIT:
            begin
                c_next     = '0;
                r_next     = '0;
                x0_next    = '0;
                x1_next    = '0;
                y0_next    = '0;
                y1_next    = '0;
                rx0_next   = '0;
                rx1_next   = tw - CFG_W'(1);
                ry0_next   = '0;
                ry1_next   = th - CFG_W'(1);
                xs_next    = '0;
                ys_next    = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                p_next = 2'd0;
                if (accept)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (pair_ok)
                begin
                    state_next = S_WR;
                end
                else if (!last_pair)
                begin
                    p_next = p_reg + 2'd1;
                end
            end
            S_WR:
            begin
                if (!last_pair)
                begin
                    p_next     = p_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_DIV:
            begin
                if (done_r && done_g && done_b)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase

        if (exiting)
        begin
            state_next = hit_reg ? S_DIV : S_IDLE;
            if (x_split || rx0_reg == '0)
            begin
                xs_next = c_reg;
            end
            if ({1'b0, c_reg} == sw - CFG_W'(1))
            begin
                c_next   = '0;
                x0_next  = '0;
                x1_next  = '0;
                rx0_next = '0;
                rx1_next = tw - CFG_W'(1);
                xs_next  = '0;
                if (y_split || ry0_reg == '0)
                begin
                    ys_next = r_reg;
                end
                if ({1'b0, r_reg} == sh - CFG_W'(1))
                begin
                    r_next   = '0;
                    y0_next  = '0;
                    y1_next  = '0;
                    ry0_next = '0;
                    ry1_next = th - CFG_W'(1);
                    ys_next  = '0;
                end
                else
                begin
                    r_next = r_reg + DIM_W'(1);
                    if (sy0 >= {1'b0, sh})
                    begin
                        ry0_next = CFG_W'(sy0 - {1'b0, sh});
                        y0_next  = y0_reg + DIM_W'(1);
                    end
                    else
                    begin
                        ry0_next = sy0[CFG_W-1:0];
                    end
                    if (sy1 >= {1'b0, sh})
                    begin
                        ry1_next = CFG_W'(sy1 - {1'b0, sh});
                        y1_next  = y1_reg + DIM_W'(1);
                    end
                    else
                    begin
                        ry1_next = sy1[CFG_W-1:0];
                    end
                end
            end
            else
            begin
                c_next = c_reg + DIM_W'(1);
                if (sx0 >= {1'b0, sw})
                begin
                    rx0_next = CFG_W'(sx0 - {1'b0, sw});
                    x0_next  = x0_reg + DIM_W'(1);
                end
                else
                begin
                    rx0_next = sx0[CFG_W-1:0];
                end
                if (sx1 >= {1'b0, sw})
                begin
                    rx1_next = CFG_W'(sx1 - {1'b0, sw});
                    x1_next  = x1_reg + DIM_W'(1);
                end
                else
                begin
                    rx1_next = sx1[CFG_W-1:0];
                end
            end
        end

        if (cfg_write)
        begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            res_valid_reg <= 1'b0;
            p_reg         <= '0;
            c_reg         <= '0;
            r_reg         <= '0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            y0_reg        <= '0;
            y1_reg        <= '0;
            rx0_reg       <= '0;
            rx1_reg       <= '0;
            ry0_reg       <= '0;
            ry1_reg       <= '0;
            xs_reg        <= '0;
            ys_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            p_reg         <= p_next;
            c_reg         <= c_next;
            r_reg         <= r_next;
            x0_reg        <= x0_next;
            x1_reg        <= x1_next;
            y0_reg        <= y0_next;
            y1_reg        <= y1_next;
            rx0_reg       <= rx0_next;
            rx1_reg       <= rx1_next;
            ry0_reg       <= ry0_next;
            ry1_reg       <= ry1_next;
            xs_reg        <= xs_next;
            ys_reg        <= ys_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg   <= pixel;
            hit_reg   <= col_end && row_end_w;
            rend_reg  <= ({1'b0, x0_reg} == tw - CFG_W'(1));
            fend_reg  <= ({1'b0, x0_reg} == tw - CFG_W'(1))
                      && ({1'b0, y0_reg} == th - CFG_W'(1));
            count_reg <= prod[CNT_W-1:0];
        end
        if (state_reg == S_OUT && (!res_valid_reg || result_ready))
        begin
            res_reg.red_out   <= mean_r;
            res_reg.green_out <= mean_g;
            res_reg.blue_out  <= mean_b;
            res_reg.row_end   <= rend_reg;
            res_reg.frame_end <= fend_reg;
        end
    end

    box_avg_lane u_lane_r
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .pix   (pix_reg.red_in),
        .mean  (mean_r),
        .done  (done_r)
    );

    box_avg_lane u_lane_g
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .pix   (pix_reg.green_in),
        .mean  (mean_g),
        .done  (done_g)
    );

    box_avg_lane u_lane_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .pix   (pix_reg.blue_in),
        .mean  (mean_b),
        .done  (done_b)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### design/box_avg_lane.sv
module box_avg_lane
    import box_avg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  logic [7:0] pix,
    output logic [7:0] mean,
    output logic       done
);

    logic [SUM_W-1:0] mem [SUM_DEPTH];
    logic [SUM_W-1:0] rdata_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] wdata;

    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [5:0]       step_reg, step_next;
    logic [7:0]       mean_reg, mean_next;
    logic             done_reg, done_next;

    logic [CNT_W:0]   trial;
    logic [CNT_W+1:0] twice_rem;
    logic             bump;

    assign wdata = ctrl.overwrite ? {{(SUM_W-8){1'b0}}, pix}
                                  : rdata_reg + {{(SUM_W-8){1'b0}}, pix};

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[ctrl.addr];
        end
        if (ctrl.wr_en && ctrl.capture)
        begin
            sum_reg <= wdata;
        end
        if (ctrl.div_start)
        begin
            cnt_reg <= ctrl.count;
        end
    end

    assign trial     = {rem_reg, dvd_reg[SUM_W-1]};
    assign twice_rem = {rem_reg, 1'b0};
    assign bump      = (twice_rem > {2'b00, cnt_reg})
                    || ((twice_rem == {2'b00, cnt_reg}) && dvd_reg[0]);

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        mean_next = mean_reg;
        done_next = 1'b0;
        if (ctrl.div_start)
        begin
            dvd_next  = sum_reg;
            rem_next  = '0;
            step_next = 6'd33;
        end
        else if (step_reg > 6'd1)
        begin
            if (trial >= {1'b0, cnt_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, cnt_reg});
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 6'd1;
        end
        else if (step_reg == 6'd1)
        begin
            mean_next = dvd_reg[7:0] + {7'd0, bump};
            done_next = 1'b1;
            step_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        mean_reg <= mean_next;
    end

    assign mean = mean_reg;
    assign done = done_reg;

endmodule
